>>> sv/pwlit_pkg.sv
// ----------------------------------------------------------------------------
// pwlit_pkg
// Types and constants for the piecewise linear interpolation table.
// ----------------------------------------------------------------------------
`default_nettype none

package pwlit_pkg;

  localparam int TableDepth = 1024;
  localparam int AddrW      = 10;
  localparam int KeyW       = 48;
  localparam int ValW       = 48;
  localparam int IdxW       = 10;
  localparam int CntW       = 11;
  localparam int StatW      = 3;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_INTERP = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_FEW      = 3'd1;
  localparam logic [StatW-1:0] ST_RANGE    = 3'd2;
  localparam logic [StatW-1:0] ST_FULL     = 3'd3;
  localparam logic [StatW-1:0] ST_BAD_IDX  = 3'd4;
  localparam logic [StatW-1:0] ST_ZERO_WID = 3'd5;

  typedef struct packed {
    logic [1:0]             action;
    logic [KeyW-1:0]        key;
    logic signed [ValW-1:0] target;
    logic [IdxW-1:0]        entry_index;
  } in_word_t;

  typedef struct packed {
    logic [StatW-1:0]       status;
    logic signed [ValW-1:0] value_out;
    logic [KeyW-1:0]        key_out;
    logic [CntW-1:0]        point_count;
    logic [KeyW-1:0]        first_key;
    logic [KeyW-1:0]        last_key;
  } out_word_t;

endpackage

`default_nettype wire

>>> sv/piecewise_linear_interp_table_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interp_table_top
// Table of (key, target) pairs with insert, read and linear interpolation.
// ----------------------------------------------------------------------------
// Usage: one request word enters on in_ (valid/stall) and one result word
// leaves on out_ (valid/stall) for each request. Pairs live in one RAM with
// a registered read port, appended in insertion order.
// Inserts and early interpolate errors go from idle straight to the done
// state; a read passes through S_RD first. A full interpolation runs a
// binary search (one RAM read per step, up to 10 steps for 1024 pairs), then
// fetches the interval ends, accumulates 48x16 partial products and ends in
// bit-serial restoring division, which takes the longest.
// One request is in flight at a time; the next request is taken once the
// previous result sits in the output register, even if out_stall holds it.
// Reset empties the table (count zero); RAM contents are left as they are.
// While out_stall is high the result word stays unchanged on out_data.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interp_table_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pwlit_pkg::in_word_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pwlit_pkg::out_word_t     out_data
);

  import pwlit_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SRCH, S_SCMP, S_LW, S_RW, S_PREP, S_MUL, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t state_r;

  logic [KeyW-1:0]        key_r;
  logic [CntW-1:0]        count_r;
  logic [KeyW-1:0]        first_r, last_r;
  logic [AddrW-1:0]       lo_r, hi_r, mid_r;
  logic [KeyW-1:0]        kl_r, kr_r;
  logic signed [ValW-1:0] tl_r, tr_r;
  logic [ValW-1:0]        mt_r;
  logic [KeyW-1:0]        mk_r, md_r;
  logic                   neg_r;
  logic [1:0]             mcnt_r;
  logic [95:0]            prod_r;
  logic [6:0]             dcnt_r;
  logic [KeyW-1:0]        rem_r;
  logic [62:0]            q_r;
  logic                   ovf_r;
  logic [StatW-1:0]       stat_r;
  logic signed [ValW-1:0] val_r;
  logic [KeyW-1:0]        kout_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [KeyW+ValW-1:0]   ram_wdata, ram_rdata;
  logic [KeyW-1:0]        rd_key;
  logic [ValW-1:0]        rd_tgt;

  assign rd_key = ram_rdata[KeyW+ValW-1:ValW];
  assign rd_tgt = ram_rdata[ValW-1:0];

  pwlit_ram #(
    .WIDTH(KeyW + ValW),
    .DEPTH(TableDepth)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic             accept;
  logic [AddrW:0]   lo_hi_sum;
  logic [AddrW-1:0] mid_c;
  logic             span_gt1;
  logic             full;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign lo_hi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c     = lo_hi_sum[AddrW:1];
  assign span_gt1  = (hi_r - lo_r) > AddrW'(1);
  assign full      = (count_r == CntW'(TableDepth));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AddrW-1:0];
    ram_wdata = {in_data.key, in_data.target};
    ram_raddr = in_data.entry_index;
    case (state_r)
      S_IDLE: begin
        ram_we = accept && (in_data.action == ACT_INSERT) && !full;
      end
      S_SRCH:  ram_raddr = span_gt1 ? mid_c : lo_r;
      S_LW:    ram_raddr = lo_r + AddrW'(1);
      default: ram_raddr = in_data.entry_index;
    endcase
  end

  // interval magnitudes and sign
  logic signed [ValW:0] dt;
  logic [KeyW:0]        dk, dd;
  assign dt = {tr_r[ValW-1], tr_r} - {tl_r[ValW-1], tl_r};
  assign dk = {1'b0, key_r} - {1'b0, kl_r};
  assign dd = {1'b0, kr_r} - {1'b0, kl_r};

  // 48x16 partial product
  logic [15:0] digit;
  logic [63:0] pp;
  logic [95:0] pp_sh;
  always_comb begin
    case (mcnt_r)
      2'd0:    digit = mk_r[15:0];
      2'd1:    digit = mk_r[31:16];
      default: digit = mk_r[47:32];
    endcase
  end
  assign pp    = mt_r * digit;
  assign pp_sh = {32'd0, pp} << {mcnt_r, 4'd0};

  // restoring division step
  logic [KeyW:0]   rem_sh;
  logic            ge;
  logic [KeyW:0]   rem_sub;
  assign rem_sh  = {rem_r, prod_r[95]};
  assign ge      = rem_sh >= {1'b0, md_r};
  assign rem_sub = rem_sh - {1'b0, md_r};

  // final add and clamp
  logic [62:0]          mag;
  logic signed [64:0]   sum;
  localparam logic signed [64:0] VMax = 65'sd140737488355327;
  localparam logic signed [64:0] VMin = -65'sd140737488355328;
  assign mag = ovf_r ? {1'b1, 62'd0} : q_r;
  assign sum = neg_r ? ({{17{tl_r[ValW-1]}}, tl_r} - {2'b00, mag})
                     : ({{17{tl_r[ValW-1]}}, tl_r} + {2'b00, mag});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r  <= in_data.key;
            stat_r <= ST_OK;
            val_r  <= '0;
            kout_r <= '0;
            lo_r   <= '0;
            hi_r   <= AddrW'(count_r - CntW'(1));
            ovf_r  <= 1'b0;
            q_r    <= '0;
            rem_r  <= '0;
            prod_r <= '0;
            mcnt_r <= '0;
            dcnt_r <= '0;
            state_r <= S_DONE;
            case (in_data.action)
              ACT_INSERT: begin
                if (full) begin
                  stat_r <= ST_FULL;
                end else begin
                  count_r <= count_r + CntW'(1);
                  last_r  <= in_data.key;
                  if (count_r == '0) begin
                    first_r <= in_data.key;
                  end
                end
              end
              ACT_INTERP: begin
                if (count_r < CntW'(2)) begin
                  stat_r <= ST_FEW;
                end else if (in_data.key < first_r || in_data.key > last_r) begin
                  stat_r <= ST_RANGE;
                end else begin
                  state_r <= S_SRCH;
                end
              end
              ACT_READ: begin
                if ({1'b0, in_data.entry_index} >= count_r) begin
                  stat_r <= ST_BAD_IDX;
                end else begin
                  state_r <= S_RD;
                end
              end
              default: stat_r <= ST_OK;
            endcase
          end
        end
        S_RD: begin
          kout_r  <= rd_key;
          val_r   <= rd_tgt;
          state_r <= S_DONE;
        end
        S_SRCH: begin
          mid_r   <= mid_c;
          state_r <= span_gt1 ? S_SCMP : S_LW;
        end
        S_SCMP: begin
          if (rd_key <= key_r) begin
            lo_r <= mid_r;
          end else begin
            hi_r <= mid_r;
          end
          state_r <= S_SRCH;
        end
        S_LW: begin
          kl_r    <= rd_key;
          tl_r    <= rd_tgt;
          state_r <= S_RW;
        end
        S_RW: begin
          kr_r    <= rd_key;
          tr_r    <= rd_tgt;
          state_r <= S_PREP;
        end
        S_PREP: begin
          if (kl_r == kr_r) begin
            stat_r  <= ST_ZERO_WID;
            state_r <= S_DONE;
          end else begin
            mt_r    <= dt[ValW] ? ValW'(-dt) : dt[ValW-1:0];
            mk_r    <= dk[KeyW] ? KeyW'(-dk) : dk[KeyW-1:0];
            md_r    <= dd[KeyW] ? KeyW'(-dd) : dd[KeyW-1:0];
            neg_r   <= dt[ValW] ^ dk[KeyW] ^ dd[KeyW];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= prod_r + pp_sh;
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd2) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (q_r[62:61] != 2'b00) begin
            ovf_r <= 1'b1;
          end
          q_r    <= {q_r[61:0], ge};
          rem_r  <= ge ? rem_sub[KeyW-1:0] : rem_sh[KeyW-1:0];
          prod_r <= {prod_r[94:0], 1'b0};
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'd95) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (sum > VMax) begin
            val_r <= ValW'(VMax);
          end else if (sum < VMin) begin
            val_r <= ValW'(VMin);
          end else begin
            val_r <= sum[ValW-1:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r            <= 1'b1;
            out_data_r.status      <= stat_r;
            out_data_r.value_out   <= (stat_r == ST_OK) ? val_r : '0;
            out_data_r.key_out     <= (stat_r == ST_OK) ? kout_r : '0;
            out_data_r.point_count <= count_r;
            out_data_r.first_key   <= (count_r == '0) ? '0 : first_r;
            out_data_r.last_key    <= (count_r == '0) ? '0 : last_r;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> sv/pwlit_ram.sv
// ----------------------------------------------------------------------------
// pwlit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlit_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
